// File: rtl/dtq_pkg.sv
// Types and constants shared by the delta list timer queue.
package dtq_pkg;

   localparam int ID_WIDTH = 4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Input transaction
   typedef struct packed {
      logic                command;
      logic [ID_WIDTH-1:0] node_id;
      logic [31:0]         delay_ticks;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic                head_valid;
      logic [ID_WIDTH-1:0] head_id;
      logic [31:0]         head_delta;
      logic                error;
   } rsp_type;

   // What the travelling token is doing at the cell it reaches
   typedef enum logic [3:0] {
      MODE_INS_SEEK  = 4'b0001,
      MODE_INS_SHIFT = 4'b0010,
      MODE_REM_SEEK  = 4'b0100,
      MODE_REM_SHIFT = 4'b1000
   } tok_mode_type;

   // Token control handed from cell to cell; node is the target id while
   // seeking and the carried id while shifting an insert
   typedef struct packed {
      logic                act;
      tok_mode_type        mode;
      logic [ID_WIDTH-1:0] node;
   } tok_ctl_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_WALK   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

endpackage

// File: rtl/dtq_cell.sv
// One list position: holds an entry and steps the token on to its neighbour.
module dtq_cell #(
   parameter int DELTA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dtq_pkg::tok_ctl_type         tok_ctl_i,
   input  logic [DELTA_WIDTH-1:0]       tok_val_i,
   input  logic                         nxt_used,
   input  logic [dtq_pkg::ID_WIDTH-1:0] nxt_node,
   input  logic [DELTA_WIDTH-1:0]       nxt_delta,
   output dtq_pkg::tok_ctl_type         tok_ctl_o,
   output logic [DELTA_WIDTH-1:0]       tok_val_o,
   output logic                         used_o,
   output logic [dtq_pkg::ID_WIDTH-1:0] node_o,
   output logic [DELTA_WIDTH-1:0]       delta_o,
   output logic                         done_o
);
   import dtq_pkg::*;

   logic                   used_ff, used_in;
   logic [ID_WIDTH-1:0]    node_ff, node_in;
   logic [DELTA_WIDTH-1:0] delta_ff, delta_in;
   tok_ctl_type            tok_ctl_ff, tok_ctl_in;
   logic [DELTA_WIDTH-1:0] tok_val_ff, tok_val_in;
   logic                   done;

   // Entry update and token hand-off
   always_comb begin
      used_in         = used_ff;
      node_in         = node_ff;
      delta_in        = delta_ff;
      tok_ctl_in      = tok_ctl_i;
      tok_ctl_in.act  = 1'b0;
      tok_val_in      = tok_val_i;
      done            = 1'b0;
      if (tok_ctl_i.act) begin
         unique case (tok_ctl_i.mode)
            MODE_INS_SEEK: begin
               if (used_ff && (tok_val_i >= delta_ff)) begin
                  // pass this entry, remainder shrinks
                  tok_ctl_in.act = 1'b1;
                  tok_val_in     = tok_val_i - delta_ff;
               end else if (used_ff) begin
                  // land here, old entry moves right and loses the remainder
                  node_in         = tok_ctl_i.node;
                  delta_in        = tok_val_i;
                  tok_ctl_in.act  = 1'b1;
                  tok_ctl_in.mode = MODE_INS_SHIFT;
                  tok_ctl_in.node = node_ff;
                  tok_val_in      = delta_ff - tok_val_i;
               end else begin
                  used_in  = 1'b1;
                  node_in  = tok_ctl_i.node;
                  delta_in = tok_val_i;
                  done     = 1'b1;
               end
            end
            MODE_INS_SHIFT: begin
               node_in  = tok_ctl_i.node;
               delta_in = tok_val_i;
               if (used_ff) begin
                  tok_ctl_in.act  = 1'b1;
                  tok_ctl_in.node = node_ff;
                  tok_val_in      = delta_ff;
               end else begin
                  used_in = 1'b1;
                  done    = 1'b1;
               end
            end
            MODE_REM_SEEK: begin
               if (used_ff && (node_ff == tok_ctl_i.node)) begin
                  if (nxt_used) begin
                     // successor inherits the removed delta
                     node_in         = nxt_node;
                     delta_in        = nxt_delta + delta_ff;
                     tok_ctl_in.act  = 1'b1;
                     tok_ctl_in.mode = MODE_REM_SHIFT;
                  end else begin
                     used_in = 1'b0;
                     done    = 1'b1;
                  end
               end else begin
                  tok_ctl_in.act = 1'b1;
               end
            end
            MODE_REM_SHIFT: begin
               if (nxt_used) begin
                  node_in        = nxt_node;
                  delta_in       = nxt_delta;
                  tok_ctl_in.act = 1'b1;
               end else begin
                  used_in = 1'b0;
                  done    = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= 1'b0;
         tok_ctl_ff.act <= 1'b0;
      end else begin
         used_ff        <= used_in;
         tok_ctl_ff.act <= tok_ctl_in.act;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      node_ff         <= node_in;
      delta_ff        <= delta_in;
      tok_ctl_ff.mode <= tok_ctl_in.mode;
      tok_ctl_ff.node <= tok_ctl_in.node;
      tok_val_ff      <= tok_val_in;
   end

   assign tok_ctl_o = tok_ctl_ff;
   assign tok_val_o = tok_val_ff;
   assign used_o    = used_ff;
   assign node_o    = node_ff;
   assign delta_o   = delta_ff;
   assign done_o    = done;

endmodule

// File: rtl/delta_timer_queue_top.sv
// Delta list timer queue: sequencer, link bits and a row of list cells.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | command, node_id, delay_ticks
//   rsp     | out       | rsp_valid / rsp_stall   | head_valid, head_id, head_delta, error
//
// A token enters cell 0 the cycle after a transaction is taken and moves one
// cell per cycle; an insert ends at the first free cell, a remove at the last
// used cell. The result register loads from the finish state once the walk has
// ended, or with no walk for an ignored transaction, and only when the output
// register is free; req_stall is high until then.
// Synchronous reset empties the list at once. A stalled result waits in the
// output register while the next transaction is taken and worked on.
module delta_timer_queue_top #(
   parameter int NODES       = 16,
   parameter int DELTA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dtq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dtq_pkg::rsp_type rsp_payload
);
   import dtq_pkg::*;

   localparam int IDX_WIDTH = (NODES > 1) ? $clog2(NODES) : 1;

   state_type              state_ff, state_in;
   tok_ctl_type            inj_ctl_ff, inj_ctl_in;
   logic [DELTA_WIDTH-1:0] inj_val_ff, inj_val_in;
   logic [NODES-1:0]       linked_ff, linked_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   tok_ctl_type            tok_ctl [NODES+1];
   logic [DELTA_WIDTH-1:0] tok_val [NODES+1];
   logic [NODES:0]         tok_act;
   logic [NODES-1:0]       cell_used;
   logic [ID_WIDTH-1:0]    cell_node  [NODES];
   logic [DELTA_WIDTH-1:0] cell_delta [NODES];
   logic [NODES-1:0]       cell_done;

   logic                   req_take;
   logic [11:0]            id_ext;
   logic [IDX_WIDTH-1:0]   id_idx;
   logic                   id_ok;
   logic                   req_err;
   logic                   walk_end;

   // Row of cells, token enters at cell 0
   assign tok_ctl[0] = inj_ctl_ff;
   assign tok_val[0] = inj_val_ff;

   for (genvar i = 0; i < NODES; i++) begin : g_cell
      logic                   n_used;
      logic [ID_WIDTH-1:0]    n_node;
      logic [DELTA_WIDTH-1:0] n_delta;
      if (i == NODES - 1) begin : g_last
         assign n_used  = 1'b0;
         assign n_node  = '0;
         assign n_delta = '0;
      end else begin : g_mid
         assign n_used  = cell_used[i+1];
         assign n_node  = cell_node[i+1];
         assign n_delta = cell_delta[i+1];
      end
      dtq_cell #(.DELTA_WIDTH(DELTA_WIDTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_ctl_i (tok_ctl[i]),
         .tok_val_i (tok_val[i]),
         .nxt_used  (n_used),
         .nxt_node  (n_node),
         .nxt_delta (n_delta),
         .tok_ctl_o (tok_ctl[i+1]),
         .tok_val_o (tok_val[i+1]),
         .used_o    (cell_used[i]),
         .node_o    (cell_node[i]),
         .delta_o   (cell_delta[i]),
         .done_o    (cell_done[i])
      );
   end

   for (genvar i = 0; i <= NODES; i++) begin : g_act
      assign tok_act[i] = tok_ctl[i].act;
   end

   // Request checks
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign id_ext    = {8'b0, req_payload.node_id};
   assign id_idx    = id_ext[IDX_WIDTH-1:0];
   assign id_ok     = ({5'b0, req_payload.node_id} < 9'(NODES));
   assign req_err   = !id_ok ||
                      ((req_payload.command == CMD_INSERT) && linked_ff[id_idx]) ||
                      ((req_payload.command == CMD_REMOVE) && !linked_ff[id_idx]);
   // a token leaving the last cell also ends the walk
   assign walk_end  = (|cell_done) || tok_act[NODES];

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      inj_ctl_in      = inj_ctl_ff;
      inj_ctl_in.act  = 1'b0;
      inj_val_in      = inj_val_ff;
      linked_in       = linked_ff;
      err_in          = err_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               err_in = req_err;
               if (req_err) begin
                  state_in = S_FINISH;
               end else begin
                  state_in        = S_WALK;
                  inj_ctl_in.act  = 1'b1;
                  inj_ctl_in.node = req_payload.node_id;
                  inj_val_in      = DELTA_WIDTH'(req_payload.delay_ticks);
                  if (req_payload.command == CMD_INSERT) begin
                     inj_ctl_in.mode   = MODE_INS_SEEK;
                     linked_in[id_idx] = 1'b1;
                  end else begin
                     inj_ctl_in.mode   = MODE_REM_SEEK;
                     linked_in[id_idx] = 1'b0;
                  end
               end
            end
         end
         S_WALK: begin
            if (walk_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // report the head once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in          = S_IDLE;
               rsp_valid_in      = 1'b1;
               rsp_in.head_valid = cell_used[0];
               rsp_in.head_id    = cell_used[0] ? cell_node[0] : '0;
               rsp_in.head_delta = cell_used[0] ? 32'(cell_delta[0]) : 32'b0;
               rsp_in.error      = err_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         inj_ctl_ff.act <= 1'b0;
         linked_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         inj_ctl_ff.act <= inj_ctl_in.act;
         linked_ff      <= linked_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      inj_ctl_ff.mode <= inj_ctl_in.mode;
      inj_ctl_ff.node <= inj_ctl_in.node;
      inj_val_ff      <= inj_val_in;
      err_ff          <= err_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Exactly one token travels while walking
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> $onehot(tok_act))
      else $error("token lost or duplicated during walk");

   // No token outside a walk
   a_no_stray_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_WALK) |-> (tok_act == '0))
      else $error("token active outside walk");

   // The list never runs past its last cell
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !tok_act[NODES])
      else $error("token ran off the end of the cell row");

   // Linked ids and used cells agree in number when idle
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(linked_ff) == $countones(cell_used)))
      else $error("link bits disagree with list length");

endmodule

// File: tb/tb_delta_timer_queue_top.sv
// Self-checking testbench for the delta list timer queue: driver, monitor and list predictor.
module tb_delta_timer_queue_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dtq_pkg::*;

   localparam int NODES          = 16;
   localparam int DELTA_WIDTH    = 32;
   localparam int HALF_PERIOD    = 4;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 2 * (NODES + 2) + 4;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 575;
   localparam int MAX_REPORTS    = 10;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   delta_timer_queue_top #(
      .NODES       (NODES),
      .DELTA_WIDTH (DELTA_WIDTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Transactions waiting to be offered, and head reports still owed by the block
   req_type timer_cmds[$];
   rsp_type head_reports[$];

   // Predicted list contents: position 0 is the head
   logic [3:0]             list_node  [NODES];
   logic [DELTA_WIDTH-1:0] list_delta [NODES];
   bit                     node_in_list [NODES];
   int                     list_len = 0;

   // Link bits as seen by the stimulus generator, one step ahead of the block
   bit gen_linked [NODES];
   int gen_count = 0;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_asked    = 0;
   int  hold_seen     = 0;
   int  hold_left     = 0;
   bit  req_taken     = 1'b0;
   int  quiet_cycles  = 0;
   int  mismatches    = 0;

   initial begin
      forever begin
         #HALF_PERIOD clock = ~clock;
      end
   end

   // Apply one command to the predicted list and work out the head report
   task automatic predict_head(input req_type cmd, output rsp_type head);
      logic [DELTA_WIDTH-1:0] rem;
      int  pos;
      int  k;
      logic err;
      begin
         err = 1'b0;
         pos = 0;
         if (int'(cmd.node_id) >= NODES) begin
            err = 1'b1;
         end else if (cmd.command == CMD_INSERT) begin
            if (node_in_list[cmd.node_id]) begin
               err = 1'b1;
            end else begin
               rem = cmd.delay_ticks;
               // walk past every entry due no later than the new one
               while (pos < list_len && rem >= list_delta[pos]) begin
                  rem = rem - list_delta[pos];
                  pos++;
               end
               if (pos < list_len) list_delta[pos] = list_delta[pos] - rem;
               for (k = list_len; k > pos; k--) begin
                  list_node[k]  = list_node[k-1];
                  list_delta[k] = list_delta[k-1];
               end
               list_node[pos]  = cmd.node_id;
               list_delta[pos] = rem;
               list_len++;
               node_in_list[cmd.node_id] = 1'b1;
            end
         end else begin
            if (!node_in_list[cmd.node_id]) begin
               err = 1'b1;
            end else begin
               while (pos < list_len && list_node[pos] != cmd.node_id) pos++;
               if (pos < list_len) begin
                  // successor inherits the removed delta; the tail hands it to nobody
                  if (pos + 1 < list_len) begin
                     list_delta[pos+1] = list_delta[pos+1] + list_delta[pos];
                  end
                  for (k = pos; k + 1 < list_len; k++) begin
                     list_node[k]  = list_node[k+1];
                     list_delta[k] = list_delta[k+1];
                  end
                  list_len--;
               end
               node_in_list[cmd.node_id] = 1'b0;
            end
         end
         head = '0;
         if (list_len > 0) begin
            head.head_valid = 1'b1;
            head.head_id    = list_node[0];
            head.head_delta = list_delta[0][31:0];
         end
         head.error = err;
      end
   endtask

   // Queue a command and track which nodes it leaves linked
   task automatic queue_cmd(input logic op, input int id, input logic [31:0] delay);
      req_type cmd;
      begin
         cmd.command     = op;
         cmd.node_id     = id[3:0];
         cmd.delay_ticks = delay;
         if (op == CMD_INSERT && !gen_linked[id]) begin
            gen_linked[id] = 1'b1;
            gen_count++;
         end else if (op == CMD_REMOVE && gen_linked[id]) begin
            gen_linked[id] = 1'b0;
            gen_count--;
         end
         timer_cmds.push_back(cmd);
      end
   endtask

   function automatic logic [31:0] pick_delay();
      int sel;
      begin
         sel = $urandom_range(99);
         if (sel < 40)      pick_delay = $urandom_range(15);
         else if (sel < 60) pick_delay = $urandom_range(255);
         else if (sel < 87) pick_delay = $urandom;
         else if (sel < 95) pick_delay = 32'hFFFF_FFFF;
         else               pick_delay = 32'hFFFF_FFFF - $urandom_range(3);
      end
   endfunction

   // Mostly well-formed inserts and removes, with some blind commands mixed in
   task automatic queue_random_cmd();
      int id;
      int ins_pct;
      begin
         if ($urandom_range(99) < 12) begin
            queue_cmd(1'($urandom_range(1)), $urandom_range(NODES-1), pick_delay());
         end else begin
            ins_pct = (gen_count < 10) ? 65 : 40;
            if (gen_count == 0 || (gen_count < NODES && $urandom_range(99) < ins_pct)) begin
               do id = $urandom_range(NODES-1); while (gen_linked[id]);
               queue_cmd(CMD_INSERT, id, pick_delay());
            end else begin
               do id = $urandom_range(NODES-1); while (!gen_linked[id]);
               queue_cmd(CMD_REMOVE, id, $urandom);
            end
         end
      end
   endtask

   // Driver: a new transaction only once the last one was taken or none is offered
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (timer_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= timer_cmds.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: predict on each taken command, check each taken head report
   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type owed;
      bit      bad;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            predict_head(req_payload, predicted);
            head_reports.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (head_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("unexpected head report: valid %0b id %0d delta %h error %0b",
                           rsp_payload.head_valid, rsp_payload.head_id,
                           rsp_payload.head_delta, rsp_payload.error);
               end
            end else begin
               owed = head_reports.pop_front();
               bad  = (rsp_payload.head_valid != owed.head_valid) ||
                      (rsp_payload.head_id    != owed.head_id)    ||
                      (rsp_payload.head_delta != owed.head_delta) ||
                      (rsp_payload.error      != owed.error);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("head mismatch: expected valid %0b id %0d delta %h error %0b,",
                              owed.head_valid, owed.head_id, owed.head_delta, owed.error,
                              " got valid %0b id %0d delta %h error %0b",
                              rsp_payload.head_valid, rsp_payload.head_id,
                              rsp_payload.head_delta, rsp_payload.error);
                  end
               end
            end
         end
         // watchdog on cycles with no transaction on either channel
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_delta_timer_queue_top: errors");
            $finish;
         end
      end
   end

   // Wait until every command is taken and every head report has come back
   task automatic wait_drained();
      begin
         while (timer_cmds.size() != 0 || req_valid || head_reports.size() != 0) begin
            @(negedge clock);
         end
         @(posedge clock);
      end
   endtask

   initial begin
      int i;
      int phase;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, equal delays, new head, extremes, errors, full list
      queue_cmd(CMD_REMOVE, 3, 32'h0);
      queue_cmd(CMD_INSERT, 5, 32'd100);
      queue_cmd(CMD_INSERT, 5, 32'd7);
      queue_cmd(CMD_INSERT, 2, 32'd100);
      queue_cmd(CMD_INSERT, 9, 32'd40);
      queue_cmd(CMD_INSERT, 0, 32'd0);
      queue_cmd(CMD_INSERT, 15, 32'hFFFF_FFFF);
      queue_cmd(CMD_INSERT, 12, 32'd0);
      queue_cmd(CMD_REMOVE, 15, 32'hFFFF_FFFF);
      queue_cmd(CMD_REMOVE, 0, 32'h0);
      queue_cmd(CMD_REMOVE, 5, 32'h0);
      queue_cmd(CMD_REMOVE, 15, 32'h0);
      for (i = 0; i < NODES; i++) begin
         if (!gen_linked[i]) queue_cmd(CMD_INSERT, i, (i * 37) % 200);
      end
      queue_cmd(CMD_INSERT, 7, 32'd1);
      wait_drained();

      // Random phases: sender idles lightly then receiver, the reverse, then no idling
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 71 : 0;
         recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 6 : 0;
         for (i = 0; i < PHASE_ITEMS; i++) queue_random_cmd();
         // hold the result side off so the block backs up against its input
         if (phase == 2) hold_asked++;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (head_reports.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("tb_delta_timer_queue_top: clean");
      end else begin
         $display("tb_delta_timer_queue_top: errors");
      end
      $finish;
   end

endmodule

// File: delta_timer_queue_top.f
rtl/dtq_pkg.sv
rtl/dtq_cell.sv
rtl/delta_timer_queue_top.sv
tb/tb_delta_timer_queue_top.sv
